// ===== src/pwcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwcs_pkg
// Shared types and codes for the priority wait counting semaphore.
// ----------------------------------------------------------------------------
package pwcs_pkg;

    localparam int WAIT_SLOTS_DEF = 8;
    localparam int TICK_BITS_DEF  = 16;
    localparam int MAX_THREADS    = 16;

    localparam logic [7:0] COUNT_MAX = 8'd255;

    localparam logic [2:0] CMD_GET  = 3'd0;
    localparam logic [2:0] CMD_PUT  = 3'd1;
    localparam logic [2:0] CMD_DEL  = 3'd2;
    localparam logic [2:0] CMD_TICK = 3'd3;
    localparam logic [2:0] CMD_SET  = 3'd4;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_TIMEOUT     = 3'd1;
    localparam logic [2:0] ST_WOULD_BLOCK = 3'd2;
    localparam logic [2:0] ST_DELETED     = 3'd3;
    localparam logic [2:0] ST_CONTEXT     = 3'd4;
    localparam logic [2:0] ST_OVERFLOW    = 3'd5;
    localparam logic [2:0] ST_FULL        = 3'd6;
    localparam logic [2:0] ST_SUSPENDED   = 3'd7;

    localparam logic [0:0] KIND_REPLY = 1'b0;
    localparam logic [0:0] KIND_WAKE  = 1'b1;

    typedef logic [2:0] pwcs_op_t;

    localparam pwcs_op_t OP_NOP    = 3'd0;
    localparam pwcs_op_t OP_INSERT = 3'd1;
    localparam pwcs_op_t OP_SHIFT  = 3'd2;
    localparam pwcs_op_t OP_TICK   = 3'd3;
    localparam pwcs_op_t OP_DROP   = 3'd4;

    typedef struct packed {
        logic       valid;
        logic       expired;
        logic [3:0] thread;
        logic [7:0] prio;
    } pwcs_entry_t;

    typedef struct packed {
        pwcs_op_t   op;
        logic [3:0] thread;
        logic [7:0] prio;
    } pwcs_ctrl_t;

    typedef struct packed {
        logic       empty;
        logic       full;
        logic [3:0] head_thread;
        logic       any_expired;
        logic [3:0] expired_thread;
    } pwcs_stat_t;

endpackage

// ===== src/priority_wait_counting_semaphore.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_wait_counting_semaphore
// Counting semaphore with a priority-ordered row of waiting threads.
// ----------------------------------------------------------------------------
// Channel   Fields (low bit first)
// s_axis    tuser: cmd; tdata: caller_thread, priority_req, wait_ticks,
//           caller_is_thread, new_count
// m_axis    tuser: report_kind; tlast: last; tdata: report_thread, status,
//           count_now
// cfg       cfg_wdata: start count, loaded into the count on cfg_we
//
// Each command is registered and runs in S_EXEC. Get, put with no waiter,
// set_count and unknown commands reply there; a put with a waiter wakes the
// head and replies in S_REPLY; delete wakes each waiter, then replies; tick
// counts down and wakes each expired waiter in S_SCAN, then replies. Results
// use the output register. Reset empties the wait row and clears the count.
// While a result waits in the output register, execution stalls; one further
// command can still be taken, and it is held until the waiting result leaves.
// ----------------------------------------------------------------------------
module priority_wait_counting_semaphore #(
    parameter int WAIT_SLOTS = pwcs_pkg::WAIT_SLOTS_DEF,
    parameter int TICK_BITS  = pwcs_pkg::TICK_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // caller_thread, priority_req, wait_ticks,
                                  // caller_is_thread, new_count
    input  logic [2:0]  s_tuser,  // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // report_thread, status, count_now
    output logic [0:0]  m_tuser,  // report_kind
    output logic        m_tlast
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_REPLY = 2'd2;
    localparam logic [1:0] S_SCAN  = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [2:0]  cmd_reg, cmd_next;
    logic [3:0]  thr_reg, thr_next;
    logic [7:0]  prio_reg, prio_next;
    logic [16:0] wt_reg, wt_next;
    logic        ctx_reg, ctx_next;
    logic [7:0]  newc_reg, newc_next;
    logic [7:0]  count_reg, count_next;

    logic        out_valid_reg, out_valid_next;
    logic [0:0]  out_kind_reg, out_kind_next;
    logic [3:0]  out_thread_reg, out_thread_next;
    logic [2:0]  out_status_reg, out_status_next;
    logic [7:0]  out_count_reg, out_count_next;
    logic        out_last_reg, out_last_next;

    pwcs_pkg::pwcs_ctrl_t ctrl;
    pwcs_pkg::pwcs_stat_t stat;
    logic [TICK_BITS-1:0] new_ticks;
    logic [31:0]          wait32;
    logic [31:0]          tmax32;
    logic [7:0]           count_op;
    logic                 can_emit;
    logic                 emit;
    logic [0:0]           e_kind;
    logic [3:0]           e_thread;
    logic [2:0]           e_status;
    logic                 e_last;

    assign s_tready = (state_reg == S_IDLE);
    assign can_emit = !out_valid_reg || m_tready;

    assign wait32    = {16'd0, wt_reg[15:0]};
    assign tmax32    = 32'((64'd1 << TICK_BITS) - 64'd1);
    assign new_ticks = (wait32 > tmax32) ? tmax32[TICK_BITS-1:0]
                                         : wait32[TICK_BITS-1:0];

    pwcs_row #(
        .WAIT_SLOTS(WAIT_SLOTS),
        .TICK_BITS (TICK_BITS)
    ) u_row (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .new_ticks (new_ticks),
        .stat      (stat)
    );

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        thr_next    = thr_reg;
        prio_next   = prio_reg;
        wt_next     = wt_reg;
        ctx_next    = ctx_reg;
        newc_next   = newc_reg;
        count_op    = count_reg;
        ctrl.op     = pwcs_pkg::OP_NOP;
        ctrl.thread = thr_reg;
        ctrl.prio   = prio_reg;
        emit        = 1'b0;
        e_kind      = pwcs_pkg::KIND_REPLY;
        e_thread    = thr_reg;
        e_status    = pwcs_pkg::ST_OK;
        e_last      = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = s_tuser;
                    thr_next   = s_tdata[3:0];
                    prio_next  = s_tdata[11:4];
                    wt_next    = s_tdata[28:12];
                    ctx_next   = s_tdata[29];
                    newc_next  = s_tdata[37:30];
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (can_emit)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    unique case (cmd_reg)
                        pwcs_pkg::CMD_GET:
                        begin
                            priority if (count_reg != 8'd0)
                            begin
                                count_op = count_reg - 8'd1;
                            end
                            else if (wt_reg[16])
                            begin
                                e_status = pwcs_pkg::ST_WOULD_BLOCK;
                            end
                            else if (!ctx_reg ||
                                     ({28'd0, thr_reg} >= 32'(pwcs_pkg::MAX_THREADS)))
                            begin
                                e_status = pwcs_pkg::ST_CONTEXT;
                            end
                            else if (stat.full)
                            begin
                                e_status = pwcs_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctrl.op  = pwcs_pkg::OP_INSERT;
                                e_status = pwcs_pkg::ST_SUSPENDED;
                            end
                        end
                        pwcs_pkg::CMD_PUT:
                        begin
                            priority if (!stat.empty)
                            begin
                                ctrl.op    = pwcs_pkg::OP_SHIFT;
                                e_kind     = pwcs_pkg::KIND_WAKE;
                                e_thread   = stat.head_thread;
                                e_last     = 1'b0;
                                state_next = S_REPLY;
                            end
                            else if (count_reg == pwcs_pkg::COUNT_MAX)
                            begin
                                e_status = pwcs_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                count_op = count_reg + 8'd1;
                            end
                        end
                        pwcs_pkg::CMD_DEL:
                        begin
                            if (!stat.empty)
                            begin
                                ctrl.op    = pwcs_pkg::OP_SHIFT;
                                e_kind     = pwcs_pkg::KIND_WAKE;
                                e_thread   = stat.head_thread;
                                e_status   = pwcs_pkg::ST_DELETED;
                                e_last     = 1'b0;
                                state_next = S_EXEC;
                            end
                        end
                        pwcs_pkg::CMD_TICK:
                        begin
                            emit       = 1'b0;
                            ctrl.op    = pwcs_pkg::OP_TICK;
                            state_next = S_SCAN;
                        end
                        pwcs_pkg::CMD_SET:
                        begin
                            count_op = newc_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_REPLY:
            begin
                if (can_emit)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (can_emit)
                begin
                    emit = 1'b1;
                    if (stat.any_expired)
                    begin
                        ctrl.op  = pwcs_pkg::OP_DROP;
                        e_kind   = pwcs_pkg::KIND_WAKE;
                        e_thread = stat.expired_thread;
                        e_status = pwcs_pkg::ST_TIMEOUT;
                        e_last   = 1'b0;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        count_next = cfg_we ? cfg_wdata : count_op;

        out_valid_next  = out_valid_reg && !m_tready;
        out_kind_next   = out_kind_reg;
        out_thread_next = out_thread_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;
        if (emit)
        begin
            out_valid_next  = 1'b1;
            out_kind_next   = e_kind;
            out_thread_next = e_thread;
            out_status_next = e_status;
            out_count_next  = count_op;
            out_last_next   = e_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        thr_reg        <= thr_next;
        prio_reg       <= prio_next;
        wt_reg         <= wt_next;
        ctx_reg        <= ctx_next;
        newc_reg       <= newc_next;
        out_kind_reg   <= out_kind_next;
        out_thread_reg <= out_thread_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_status_reg, out_thread_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== src/pwcs_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwcs_cell
// One slot of the wait row: holds a waiter and trades it with its neighbors.
// ----------------------------------------------------------------------------
module pwcs_cell #(
    parameter int TICK_BITS = pwcs_pkg::TICK_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pwcs_pkg::pwcs_ctrl_t  ctrl,
    input  logic [TICK_BITS-1:0]  new_ticks,
    input  pwcs_pkg::pwcs_entry_t left_entry,
    input  logic [TICK_BITS-1:0]  left_ticks,
    input  logic                  left_greater,
    input  pwcs_pkg::pwcs_entry_t right_entry,
    input  logic [TICK_BITS-1:0]  right_ticks,
    input  logic                  seen_in,
    input  logic [3:0]            pick_in,
    output pwcs_pkg::pwcs_entry_t entry,
    output logic [TICK_BITS-1:0]  ticks,
    output logic                  greater,
    output logic                  seen_out,
    output logic [3:0]            pick_out
);

    pwcs_pkg::pwcs_entry_t entry_reg, entry_next;
    logic [TICK_BITS-1:0]  ticks_reg, ticks_next;

    assign entry    = entry_reg;
    assign ticks    = ticks_reg;
    assign greater  = !entry_reg.valid || (entry_reg.prio > ctrl.prio);
    assign seen_out = seen_in || (entry_reg.valid && entry_reg.expired);
    assign pick_out = seen_in ? pick_in : entry_reg.thread;

    always_comb
    begin
        entry_next = entry_reg;
        ticks_next = ticks_reg;
        unique case (ctrl.op)
            pwcs_pkg::OP_INSERT:
            begin
                if (greater && !left_greater)
                begin
                    entry_next.valid   = 1'b1;
                    entry_next.expired = 1'b0;
                    entry_next.thread  = ctrl.thread;
                    entry_next.prio    = ctrl.prio;
                    ticks_next         = new_ticks;
                end
                else if (greater)
                begin
                    entry_next = left_entry;
                    ticks_next = left_ticks;
                end
            end
            pwcs_pkg::OP_SHIFT:
            begin
                entry_next = right_entry;
                ticks_next = right_ticks;
            end
            pwcs_pkg::OP_TICK:
            begin
                if (entry_reg.valid && (ticks_reg != '0))
                begin
                    ticks_next         = ticks_reg - 1'b1;
                    entry_next.expired = (ticks_reg == TICK_BITS'(1));
                end
            end
            pwcs_pkg::OP_DROP:
            begin
                if (seen_out)
                begin
                    entry_next = right_entry;
                    ticks_next = right_ticks;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
            ticks_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
            ticks_reg <= ticks_next;
        end
    end

endmodule

// ===== src/pwcs_row.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwcs_row
// Row of wait cells kept in wake order, head in cell zero.
// ----------------------------------------------------------------------------
module pwcs_row #(
    parameter int WAIT_SLOTS = pwcs_pkg::WAIT_SLOTS_DEF,
    parameter int TICK_BITS  = pwcs_pkg::TICK_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pwcs_pkg::pwcs_ctrl_t ctrl,
    input  logic [TICK_BITS-1:0] new_ticks,
    output pwcs_pkg::pwcs_stat_t stat
);

    pwcs_pkg::pwcs_entry_t ent      [WAIT_SLOTS];
    logic [TICK_BITS-1:0]  tck      [WAIT_SLOTS];
    logic                  grt      [WAIT_SLOTS];
    logic                  seen     [WAIT_SLOTS];
    logic [3:0]            pick     [WAIT_SLOTS];
    pwcs_pkg::pwcs_entry_t l_ent    [WAIT_SLOTS];
    logic [TICK_BITS-1:0]  l_tck    [WAIT_SLOTS];
    logic                  l_grt    [WAIT_SLOTS];
    logic                  l_seen   [WAIT_SLOTS];
    logic [3:0]            l_pick   [WAIT_SLOTS];
    pwcs_pkg::pwcs_entry_t r_ent    [WAIT_SLOTS];
    logic [TICK_BITS-1:0]  r_tck    [WAIT_SLOTS];

    for (genvar i = 0; i < WAIT_SLOTS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            assign l_ent[i]  = '0;
            assign l_tck[i]  = '0;
            assign l_grt[i]  = 1'b0;
            assign l_seen[i] = 1'b0;
            assign l_pick[i] = '0;
        end
        else
        begin : g_inner
            assign l_ent[i]  = ent[i-1];
            assign l_tck[i]  = tck[i-1];
            assign l_grt[i]  = grt[i-1];
            assign l_seen[i] = seen[i-1];
            assign l_pick[i] = pick[i-1];
        end

        if (i == WAIT_SLOTS - 1)
        begin : g_last
            assign r_ent[i] = '0;
            assign r_tck[i] = '0;
        end
        else
        begin : g_mid
            assign r_ent[i] = ent[i+1];
            assign r_tck[i] = tck[i+1];
        end

        pwcs_cell #(
            .TICK_BITS(TICK_BITS)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .new_ticks    (new_ticks),
            .left_entry   (l_ent[i]),
            .left_ticks   (l_tck[i]),
            .left_greater (l_grt[i]),
            .right_entry  (r_ent[i]),
            .right_ticks  (r_tck[i]),
            .seen_in      (l_seen[i]),
            .pick_in      (l_pick[i]),
            .entry        (ent[i]),
            .ticks        (tck[i]),
            .greater      (grt[i]),
            .seen_out     (seen[i]),
            .pick_out     (pick[i])
        );
    end

    assign stat.empty          = !ent[0].valid;
    assign stat.full           = ent[WAIT_SLOTS-1].valid;
    assign stat.head_thread    = ent[0].thread;
    assign stat.any_expired    = seen[WAIT_SLOTS-1];
    assign stat.expired_thread = pick[WAIT_SLOTS-1];

endmodule

// ===== tb/sv/priority_wait_counting_semaphore_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_wait_counting_semaphore_test
// Self-checking bench for the counting semaphore with its priority wait row.
// Commands go in on the slave stream. A built-in predictor keeps the count
// and the ordered wait row, and queues the wake notices and the reply that
// each accepted command should produce. Every transfer on the master stream
// is checked field by field against the oldest queued result. Directed
// commands cover blocking, context, full-row, wake-order, timeout, delete and
// overflow cases. Random commands then run under several levels of sender
// idling and receiver stalling, with the initial count reloaded in between.
// ----------------------------------------------------------------------------
module priority_wait_counting_semaphore_test;

    localparam int          SLOTS        = pwcs_pkg::WAIT_SLOTS_DEF;
    localparam logic [2:0]  CMD_RSVD_LO  = 3'd5;
    localparam logic [2:0]  CMD_RSVD_HI  = 3'd7;
    localparam logic [16:0] WAIT_NEVER   = 17'h1ffff;
    localparam logic [16:0] WAIT_FOREVER = 17'd0;
    localparam logic [16:0] WAIT_LONGEST = 17'h0ffff;
    localparam int          QUIET_LIMIT  = 4000;

    typedef struct packed {
        logic [0:0] kind;
        logic [3:0] thread;
        logic [2:0] status;
        logic [7:0] count;
        logic       last;
    } sem_report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // caller_thread, priority_req, wait_ticks,
                                 // caller_is_thread, new_count
    logic [2:0]  s_tuser = '0;   // cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // report_thread, status, count_now
    logic [0:0]  m_tuser;        // report_kind
    logic        m_tlast;

    logic [7:0]  sem_cnt = '0;
    logic [3:0]  wq_thread [SLOTS];
    logic [7:0]  wq_prio [SLOTS];
    logic [15:0] wq_ticks [SLOTS];
    int          wq_fill = 0;
    sem_report_t pending_reports [$];

    int src_idle_pct = 0;
    int dst_stall_pct = 0;
    int fail_cnt = 0;
    int cmd_cnt = 0;
    int report_cnt = 0;
    int wake_cnt = 0;
    int cfg_cnt = 0;
    int quiet_cycles = 0;

    priority_wait_counting_semaphore u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void push_report(logic [0:0] kind, logic [3:0] thr, logic [2:0] st,
                                        logic fin);
        pending_reports.push_back(sem_report_t'{kind, thr, st, sem_cnt, fin});
    endfunction

    function automatic void drop_waiter(int idx);
        int i;
        for (i = idx; i + 1 < wq_fill; i++)
        begin
            wq_thread[i] = wq_thread[i + 1];
            wq_prio[i]   = wq_prio[i + 1];
            wq_ticks[i]  = wq_ticks[i + 1];
        end
        if (wq_fill > 0)
            wq_fill--;
    endfunction

    function automatic void predict_command(logic [2:0] cmd, logic [3:0] thr, logic [7:0] prio,
                                            logic [16:0] wt, logic is_thr, logic [7:0] newc);
        int pos;
        int i;
        logic [2:0] st;
        st = pwcs_pkg::ST_OK;
        case (cmd)
            pwcs_pkg::CMD_GET:
            begin
                if (sem_cnt != 8'd0)
                    sem_cnt = sem_cnt - 8'd1;
                else if (wt[16])
                    st = pwcs_pkg::ST_WOULD_BLOCK;
                else if (!is_thr || int'(thr) >= pwcs_pkg::MAX_THREADS)
                    st = pwcs_pkg::ST_CONTEXT;
                else if (wq_fill >= SLOTS)
                    st = pwcs_pkg::ST_FULL;
                else
                begin
                    pos = 0;
                    while (pos < wq_fill && wq_prio[pos] <= prio)
                        pos++;
                    for (i = wq_fill; i > pos; i--)
                    begin
                        wq_thread[i] = wq_thread[i - 1];
                        wq_prio[i]   = wq_prio[i - 1];
                        wq_ticks[i]  = wq_ticks[i - 1];
                    end
                    wq_thread[pos] = thr;
                    wq_prio[pos]   = prio;
                    wq_ticks[pos]  = wt[15:0];
                    wq_fill++;
                    st = pwcs_pkg::ST_SUSPENDED;
                end
            end
            pwcs_pkg::CMD_PUT:
            begin
                if (wq_fill > 0)
                begin
                    push_report(pwcs_pkg::KIND_WAKE, wq_thread[0], pwcs_pkg::ST_OK, 1'b0);
                    drop_waiter(0);
                end
                else if (sem_cnt == pwcs_pkg::COUNT_MAX)
                    st = pwcs_pkg::ST_OVERFLOW;
                else
                    sem_cnt = sem_cnt + 8'd1;
            end
            pwcs_pkg::CMD_DEL:
            begin
                while (wq_fill > 0)
                begin
                    push_report(pwcs_pkg::KIND_WAKE, wq_thread[0], pwcs_pkg::ST_DELETED, 1'b0);
                    drop_waiter(0);
                end
            end
            pwcs_pkg::CMD_TICK:
            begin
                i = 0;
                while (i < wq_fill)
                begin
                    if (wq_ticks[i] == 16'd1)
                    begin
                        push_report(pwcs_pkg::KIND_WAKE, wq_thread[i], pwcs_pkg::ST_TIMEOUT,
                                    1'b0);
                        drop_waiter(i);
                    end
                    else
                    begin
                        if (wq_ticks[i] != 16'd0)
                            wq_ticks[i] = wq_ticks[i] - 16'd1;
                        i++;
                    end
                end
            end
            pwcs_pkg::CMD_SET:
                sem_cnt = newc;
            default:
                st = pwcs_pkg::ST_OK;
        endcase
        push_report(pwcs_pkg::KIND_REPLY, thr, st, 1'b1);
    endfunction

    task automatic send_cmd(input logic [2:0] cmd, input logic [3:0] thr, input logic [7:0] prio,
                            input logic [16:0] wt, input logic is_thr, input logic [7:0] newc);
        while (int'($urandom_range(99)) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, newc, is_thr, wt, prio, thr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_command(cmd, thr, prio, wt, is_thr, newc);
        cmd_cnt++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_start_count(input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sem_cnt = value;
        cfg_cnt++;
    endtask

    task automatic send_random_cmd();
        int roll;
        logic [2:0]  cmd;
        logic [16:0] wt;
        logic [7:0]  prio;
        logic [7:0]  newc;
        roll = $urandom_range(99);
        if (roll < 42)
            cmd = pwcs_pkg::CMD_GET;
        else if (roll < 66)
            cmd = pwcs_pkg::CMD_PUT;
        else if (roll < 84)
            cmd = pwcs_pkg::CMD_TICK;
        else if (roll < 88)
            cmd = pwcs_pkg::CMD_DEL;
        else if (roll < 95)
            cmd = pwcs_pkg::CMD_SET;
        else
            cmd = 3'($urandom_range(CMD_RSVD_HI, CMD_RSVD_LO));
        roll = $urandom_range(99);
        if (roll < 15)
            wt = {1'b1, 16'($urandom)};
        else if (roll < 25)
            wt = WAIT_FOREVER;
        else if (roll < 85)
            wt = 17'($urandom_range(6, 1));
        else
            wt = {1'b0, 16'($urandom)};
        prio = ($urandom_range(1) != 0) ? 8'($urandom_range(3)) : 8'($urandom);
        newc = ($urandom_range(3) != 0) ? 8'($urandom_range(2)) : 8'($urandom);
        send_cmd(cmd, 4'($urandom), prio, wt, int'($urandom_range(99)) < 88, newc);
    endtask

    task automatic test_blocking_replies();
        send_cmd(pwcs_pkg::CMD_GET, 4'd1, 8'd0, WAIT_NEVER, 1'b1, 8'd0);
        send_cmd(pwcs_pkg::CMD_GET, 4'd2, 8'd9, 17'h10000, 1'b1, 8'hff);
        send_cmd(pwcs_pkg::CMD_GET, 4'd0, 8'hff, WAIT_FOREVER, 1'b0, 8'd0);
    endtask

    task automatic test_wait_order();
        send_cmd(pwcs_pkg::CMD_GET, 4'd15, 8'hff, WAIT_FOREVER, 1'b1, 8'd0);
        send_cmd(pwcs_pkg::CMD_GET, 4'd3, 8'd0, 17'd2, 1'b1, 8'd0);
        send_cmd(pwcs_pkg::CMD_GET, 4'd3, 8'd0, WAIT_LONGEST, 1'b1, 8'd0);
        send_cmd(pwcs_pkg::CMD_GET, 4'd7, 8'd0, 17'd1, 1'b1, 8'd0);
        send_cmd(pwcs_pkg::CMD_TICK, 4'd4, 8'd0, WAIT_FOREVER, 1'b1, 8'd0);
        send_cmd(pwcs_pkg::CMD_TICK, 4'd5, 8'd0, WAIT_FOREVER, 1'b1, 8'd0);
        send_cmd(pwcs_pkg::CMD_PUT, 4'd6, 8'd0, WAIT_FOREVER, 1'b1, 8'd0);
    endtask

    task automatic test_full_table();
        int n;
        for (n = 0; n < SLOTS - 1; n++)
            send_cmd(pwcs_pkg::CMD_GET, 4'(n + 8), 8'(n * 37), WAIT_FOREVER, 1'b1, 8'd0);
        send_cmd(pwcs_pkg::CMD_GET, 4'd9, 8'd1, WAIT_FOREVER, 1'b1, 8'd0);
        send_cmd(pwcs_pkg::CMD_GET, 4'd10, 8'd1, WAIT_FOREVER, 1'b0, 8'd0);
    endtask

    task automatic test_count_limits();
        send_cmd(pwcs_pkg::CMD_SET, 4'd1, 8'd0, WAIT_FOREVER, 1'b1, 8'd5);
        send_cmd(pwcs_pkg::CMD_GET, 4'd2, 8'd0, WAIT_NEVER, 1'b1, 8'd0);
        send_cmd(pwcs_pkg::CMD_DEL, 4'd3, 8'd0, WAIT_FOREVER, 1'b1, 8'd0);
        send_cmd(pwcs_pkg::CMD_SET, 4'd4, 8'd0, WAIT_FOREVER, 1'b1, 8'hff);
        send_cmd(pwcs_pkg::CMD_PUT, 4'd5, 8'd0, WAIT_FOREVER, 1'b1, 8'd0);
    endtask

    task automatic test_unknown_cmds();
        send_cmd(CMD_RSVD_LO, 4'd11, 8'd0, WAIT_FOREVER, 1'b1, 8'd0);
        send_cmd(CMD_RSVD_HI, 4'd12, 8'hff, WAIT_NEVER, 1'b0, 8'hff);
    endtask

    task automatic test_config_reload();
        wait_idle();
        write_start_count(8'hff);
        send_cmd(pwcs_pkg::CMD_PUT, 4'd13, 8'd0, WAIT_FOREVER, 1'b1, 8'd0);
        wait_idle();
        write_start_count(8'd0);
        send_cmd(pwcs_pkg::CMD_GET, 4'd14, 8'd0, WAIT_NEVER, 1'b1, 8'd0);
    endtask

    task automatic test_random_phase(input int src_pct, input int dst_pct, input int n,
                                     input logic [7:0] start_count);
        wait_idle();
        src_idle_pct  = src_pct;
        dst_stall_pct = dst_pct;
        write_start_count(start_count);
        repeat (n) send_random_cmd();
    endtask

    always @(posedge clk)
        m_tready <= (int'($urandom_range(99)) >= dst_stall_pct);

    always @(posedge clk)
    begin : check_reports
        sem_report_t got;
        sem_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = sem_report_t'{m_tuser, m_tdata[3:0], m_tdata[6:4], m_tdata[14:7], m_tlast};
            report_cnt++;
            if (got.kind == pwcs_pkg::KIND_WAKE)
                wake_cnt++;
            if (pending_reports.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("ERROR: unexpected kind=%0d thr=%0d st=%0d cnt=%0d last=%0d",
                             got.kind, got.thread, got.status, got.count, got.last);
            end
            else
            begin
                want = pending_reports.pop_front();
                if (got.kind !== want.kind || got.thread !== want.thread ||
                    got.status !== want.status || got.count !== want.count ||
                    got.last !== want.last)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                    begin
                        $display(
                            "ERROR: result %0d expected kind=%0d thr=%0d st=%0d cnt=%0d last=%0d",
                            report_cnt, want.kind, want.thread, want.status, want.count,
                            want.last);
                        $display(
                            "       result %0d actual   kind=%0d thr=%0d st=%0d cnt=%0d last=%0d",
                            report_cnt, got.kind, got.thread, got.status, got.count,
                            got.last);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("ERROR: no transfer for %0d cycles", QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_blocking_replies();
        test_wait_order();
        test_full_table();
        test_count_limits();
        test_unknown_cmds();
        test_config_reload();
        test_random_phase(0, 0, 108, 8'd3);
        test_random_phase(52, 0, 108, 8'hff);
        test_random_phase(0, 52, 108, 8'd0);
        test_random_phase(32, 32, 108, 8'($urandom));
        wait_idle();
        repeat (16) @(posedge clk);
        if (pending_reports.size() != 0)
        begin
            fail_cnt++;
            $display("ERROR: %0d expected results never arrived", pending_reports.size());
        end
        $display("Ran %0d commands and checked %0d results, %0d of them wake notices.",
                 cmd_cnt, report_cnt, wake_cnt);
        $display("The initial count was loaded %0d times under four stall settings.", cfg_cnt);
        if (fail_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/pwcs_pkg.sv
src/pwcs_cell.sv
src/pwcs_row.sv
src/priority_wait_counting_semaphore.sv
tb/sv/priority_wait_counting_semaphore_test.sv
